// ===== rtl/loq_pkg.sv =====
// shared request and status codes for the lru order queue
`default_nettype none

package loq_pkg;

  localparam int unsigned CAP_W   = 5;
  localparam int unsigned COUNT_W = 5;

  localparam logic [1:0] REQ_ENQ  = 2'd0;
  localparam logic [1:0] REQ_DEQ  = 2'd1;
  localparam logic [1:0] REQ_PEEK = 2'd2;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

endpackage

`default_nettype wire

// ===== rtl/lru_order_queue.sv =====
// lru order queue: packed list of ids with move-to-most-recent, walked by one sweep engine
//
// usage
//   a request transaction is taken at a rising edge with start_i high and busy_o low;
//   req_type_i selects enqueue, dequeue or peek (code three behaves as peek) and
//   proc_id_i carries the id for an enqueue
//   each request gives exactly one result: done_o is high for one cycle with
//   status_o, head_id_o and entry_count_o valid in that cycle; the receiver has
//   no way to stall, and those three outputs hold until the next result replaces them
//   capacity is written through cfg_we_i / cfg_wdata_i by the user only while idle, which
//   the block does not check; values above DEPTH act as DEPTH, zero rejects every enqueue
// timing
//   a full enqueue or an empty dequeue/peek answers from the count alone: done_o
//   rises in the cycle after the request and busy_o never goes high
//   otherwise the list lives in a one-read one-write memory and a sweep reads one
//   entry per cycle: enqueue and dequeue walk the held entries, peek reads only the head,
//   an enqueue into an empty list only writes the new id; the read port sets the pace
//   busy_o stays high until the strobe cycle, where a new request may already start
// reset
//   rst_ni clears the count to empty and the capacity to 16; the memory itself is
//   not cleared, entries at or above the count are never read
`default_nettype none

module lru_order_queue #(
  parameter int unsigned DEPTH    = 16,
  parameter int unsigned ID_WIDTH = 16
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  output      logic                       busy_o,
  input  wire logic [1:0]                 req_type_i,
  input  wire logic [ID_WIDTH-1:0]        proc_id_i,
  input  wire logic                       cfg_we_i,
  input  wire logic [loq_pkg::CAP_W-1:0]  cfg_wdata_i,
  output      logic                       done_o,
  output      logic [1:0]                 status_o,
  output      logic [ID_WIDTH-1:0]        head_id_o,
  output      logic [loq_pkg::COUNT_W-1:0] entry_count_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  typedef enum logic {
    ST_IDLE,
    ST_SWEEP
  } state_e;

  // list storage, entry 0 is the oldest
  logic [ID_WIDTH-1:0] mem_q [DEPTH];
  logic [ID_WIDTH-1:0] rd_data_q;
  logic [AW-1:0]       mem_raddr;
  logic [AW-1:0]       mem_waddr;
  logic [ID_WIDTH-1:0] mem_wdata;
  logic                mem_we;

  state_e                      state_q, state_d;
  logic [CW-1:0]               cnt_q, cnt_d;
  logic [loq_pkg::CAP_W-1:0]   cap_q, cap_d;
  logic [1:0]                  op_q, op_d;
  logic [ID_WIDTH-1:0]         id_q, id_d;
  logic [CW-1:0]               rd_idx_q, rd_idx_d;
  logic [CW-1:0]               wr_idx_q, wr_idx_d;
  logic [CW-1:0]               end_q, end_d;
  logic                        pend_q, pend_d;
  logic                        first_q, first_d;
  logic [ID_WIDTH-1:0]         head_q, head_d;
  logic                        done_q, done_d;
  logic [1:0]                  status_q, status_d;
  logic [ID_WIDTH-1:0]         head_out_q, head_out_d;
  logic [loq_pkg::COUNT_W-1:0] count_out_q, count_out_d;

  logic is_enq;
  logic at_limit;
  logic rd_go;
  logic capture;
  logic keep;
  logic finish;

  // request accepted only when idle
  assign busy_o = (state_q != ST_IDLE);

  assign is_enq   = (op_q == loq_pkg::REQ_ENQ);
  // capacity saturates at DEPTH
  assign at_limit = (32'(cnt_q) >= 32'(cap_q)) || (32'(cnt_q) >= 32'(DEPTH));

  // sweep pipeline: read one entry per cycle, act on it the next
  assign rd_go   = (state_q == ST_SWEEP) && (rd_idx_q < end_q);
  // first entry of a dequeue or peek is the head, it is taken and not written back
  assign capture = pend_q && first_q && !is_enq;
  // enqueue drops copies of the new id, dequeue keeps everything behind the head
  assign keep    = pend_q && !capture && (!is_enq || (rd_data_q != id_q));
  assign finish  = (state_q == ST_SWEEP) && !rd_go && !pend_q;

  assign mem_raddr = rd_idx_q[AW-1:0];
  assign mem_waddr = wr_idx_q[AW-1:0];
  assign mem_wdata = keep ? rd_data_q : id_q;
  assign mem_we    = keep || (finish && is_enq);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= mem_q[mem_raddr];
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    cap_d       = cap_q;
    op_d        = op_q;
    id_d        = id_q;
    rd_idx_d    = rd_idx_q;
    wr_idx_d    = wr_idx_q;
    end_d       = end_q;
    pend_d      = 1'b0;
    first_d     = first_q;
    head_d      = head_q;
    done_d      = 1'b0;
    status_d    = status_q;
    head_out_d  = head_out_q;
    count_out_d = count_out_q;

    if (cfg_we_i) begin
      cap_d = cfg_wdata_i;
    end

    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          op_d     = req_type_i;
          id_d     = proc_id_i;
          rd_idx_d = '0;
          wr_idx_d = '0;
          first_d  = 1'b1;
          head_d   = '0;
          if (req_type_i == loq_pkg::REQ_ENQ) begin
            if (at_limit) begin
              done_d      = 1'b1;
              status_d    = loq_pkg::STAT_FULL;
              head_out_d  = '0;
              count_out_d = loq_pkg::COUNT_W'(cnt_q);
            end else begin
              end_d   = cnt_q;
              state_d = ST_SWEEP;
            end
          end else if (cnt_q == '0) begin
            done_d      = 1'b1;
            status_d    = loq_pkg::STAT_EMPTY;
            head_out_d  = '0;
            count_out_d = loq_pkg::COUNT_W'(cnt_q);
          end else begin
            // peek only needs the head
            end_d   = (req_type_i == loq_pkg::REQ_DEQ) ? cnt_q : CW'(1);
            state_d = ST_SWEEP;
          end
        end
      end

      ST_SWEEP: begin
        if (rd_go) begin
          rd_idx_d = rd_idx_q + CW'(1);
          pend_d   = 1'b1;
        end
        if (pend_q) begin
          first_d = 1'b0;
        end
        if (capture) begin
          head_d = rd_data_q;
        end
        if (keep) begin
          wr_idx_d = wr_idx_q + CW'(1);
        end
        if (finish) begin
          if (is_enq) begin
            cnt_d = wr_idx_q + CW'(1);
          end else if (op_q == loq_pkg::REQ_DEQ) begin
            cnt_d = wr_idx_q;
          end
          done_d      = 1'b1;
          status_d    = loq_pkg::STAT_OK;
          head_out_d  = head_q;
          count_out_d = is_enq ? loq_pkg::COUNT_W'(wr_idx_q + CW'(1)) :
                        (op_q == loq_pkg::REQ_DEQ) ? loq_pkg::COUNT_W'(wr_idx_q) :
                        loq_pkg::COUNT_W'(cnt_q);
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      cap_q       <= loq_pkg::CAP_RESET;
      pend_q      <= 1'b0;
      first_q     <= 1'b0;
      done_q      <= 1'b0;
      op_q        <= loq_pkg::REQ_PEEK;
      id_q        <= '0;
      rd_idx_q    <= '0;
      wr_idx_q    <= '0;
      end_q       <= '0;
      head_q      <= '0;
      status_q    <= loq_pkg::STAT_OK;
      head_out_q  <= '0;
      count_out_q <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      cap_q       <= cap_d;
      pend_q      <= pend_d;
      first_q     <= first_d;
      done_q      <= done_d;
      op_q        <= op_d;
      id_q        <= id_d;
      rd_idx_q    <= rd_idx_d;
      wr_idx_q    <= wr_idx_d;
      end_q       <= end_d;
      head_q      <= head_d;
      status_q    <= status_d;
      head_out_q  <= head_out_d;
      count_out_q <= count_out_d;
    end
  end

  assign done_o        = done_q;
  assign status_o      = status_q;
  assign head_id_o     = head_out_q;
  assign entry_count_o = count_out_q;

endmodule

`default_nettype wire
